// ===== hw/rtl/rnbe_pkg.sv =====
// Shared types, codes and defaults for the R-tree node branch engine.
`default_nettype none
package rnbe_pkg;

  // Default node geometry.
  localparam int NODE_SLOTS_DEF = 16;
  localparam int COORD_BITS_DEF = 16;

  // Fixed field widths of the stream words.
  localparam int FIELD_W = 16;
  localparam int CHILD_W = 24;
  localparam int TDATA_W = 96;

  // Operation codes.
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_CHOOSE = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;
  localparam logic [1:0] FN_FIND   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  // One queued operation; coordinates are already masked.
  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         slot_index;
    logic [FIELD_W-1:0] x_low;
    logic [FIELD_W-1:0] y_low;
    logic [FIELD_W-1:0] x_high;
    logic [FIELD_W-1:0] y_high;
    logic [CHILD_W-1:0] child_ref;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         chosen_slot;
    logic [CHILD_W-1:0] chosen_child;
    logic [FIELD_W-1:0] cover_x_low;
    logic [FIELD_W-1:0] cover_y_low;
    logic [FIELD_W-1:0] cover_x_high;
    logic [FIELD_W-1:0] cover_y_high;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rtree_node_branch_engine_core.sv =====
// Top level of the R-tree node branch engine.
`default_nettype none
// One R-tree node of NODE_SLOTS branch slots that inserts, chooses the
// least-enlargement slot, clears and finds equal rectangles. In the
// execution unit an operation starts from idle, reads one slot from the
// slot memory per cycle, passes each slot through the pipeline stages for
// area and growth, and then loads the result register. A finished
// operation waits in the execution unit only while the result register
// still holds an unaccepted word. A two-entry queue in front keeps
// accepting words while an operation runs or a result waits, until it is
// full. Every result carries the cover of the valid slots after the
// operation. Slot storage needs no clearing after reset.
module rtree_node_branch_engine_core import rnbe_pkg::*; #(
  parameter int NODE_SLOTS = NODE_SLOTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // func, slot_index, x_low, y_low, x_high, y_high, child_ref, zero pad
  input  wire logic [TDATA_W-1:0] in_tdata,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // status, chosen_slot, chosen_child, cover_x_low, cover_y_low,
  // cover_x_high, cover_y_high, zero pad
  output logic      [TDATA_W-1:0] out_tdata
);

  logic    q_valid, q_ready;
  item_t   q_item;
  result_t res;

  rnbe_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  rnbe_back #(.NODE_SLOTS(NODE_SLOTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  // Pack the result word, first field in the lowest bits.
  assign out_tdata = {2'b00, res.cover_y_high, res.cover_x_high, res.cover_y_low,
                      res.cover_x_low, res.chosen_child, res.chosen_slot, res.status};

endmodule
`default_nettype wire

// ===== hw/rtl/rnbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rnbe_ram #(
  parameter int WIDTH = 88,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rnbe_front.sv =====
// Front end: accepts input words, masks coordinates and queues operations.
`default_nettype none
module rnbe_front import rnbe_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output item_t                   q_item
);

  localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam logic [FIELD_W-1:0] CMASK = FIELD_W'((32'd1 << CW) - 32'd1);

  item_t      item;
  item_t      fifo_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  // Unpack the word and keep only the used coordinate bits.
  always_comb begin
    item.func       = in_tdata[1:0];
    item.slot_index = in_tdata[5:2];
    item.x_low      = in_tdata[21:6] & CMASK;
    item.y_low      = in_tdata[37:22] & CMASK;
    item.x_high     = in_tdata[53:38] & CMASK;
    item.y_high     = in_tdata[69:54] & CMASK;
    item.child_ref  = in_tdata[93:70];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = fifo_r[rptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  // Two-entry queue between the accept side and the execution side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        fifo_r[wptr_r] <= item;
        wptr_r         <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rnbe_back.sv =====
// Back end: executes one operation by walking the slot memory and holds the result.
`default_nettype none
module rnbe_back import rnbe_pkg::*; #(
  parameter int NODE_SLOTS = NODE_SLOTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  output logic      q_ready,
  input  item_t     q_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_data
);

  localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int SW = $clog2(NODE_SLOTS);
  localparam int RW = 4 * CW + CHILD_W;
  localparam int AW = 2 * CW;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

  function automatic logic [3:0] low4(input logic [SW-1:0] v);
    logic [SW+3:0] e;
    e = (SW+4)'(v);
    return e[3:0];
  endfunction

  state_t               state_r;
  logic [NODE_SLOTS-1:0] valid_r;
  item_t                op_r;
  logic [SW:0]          rd_idx_r;
  logic                 s1_vld_r;
  logic [SW-1:0]        s1_idx_r;
  logic                 s2_vld_r, s2_live_r;
  logic [SW-1:0]        s2_idx_r;
  logic [AW-1:0]        s2_a_r, s2_ga_r;
  logic [CW-1:0]        s2_xl_r, s2_yl_r, s2_xh_r, s2_yh_r;
  logic [CHILD_W-1:0]   s2_child_r;
  logic [1:0]           status_r;
  logic [3:0]           slot_r;
  logic [CHILD_W-1:0]   child_r;
  logic [SW-1:0]        clr_idx_r;
  logic [AW-1:0]        best_inc_r, best_a_r;
  logic                 any_r;
  logic [CW-1:0]        cxl_r, cyl_r, cxh_r, cyh_r;
  logic                 out_vld_r;
  result_t              res_r;
  logic                 load_res;

  logic                 ram_we;
  logic [SW-1:0]        ram_waddr, ram_raddr;
  logic [RW-1:0]        ram_wdata, ram_rdata;

  // Lowest free slot.
  logic          free_any;
  logic [SW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NODE_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // Clear-slot range and occupancy check.
  logic [SW+3:0] sx;
  logic          clr_hit;
  assign sx      = (SW+4)'(q_item.slot_index);
  assign clr_hit = (sx < (SW+4)'(NODE_SLOTS)) && valid_r[sx[SW-1:0]];

  // A finished operation moves to the result register once it is free.
  assign load_res  = (state_r == S_DONE) && (!out_vld_r || out_ready);
  assign q_ready   = (state_r == S_IDLE);
  assign ram_we    = q_ready && q_valid && (q_item.func == FN_INSERT) && free_any;
  assign ram_waddr = free_idx;
  assign ram_wdata = {q_item.child_ref, q_item.y_high[CW-1:0], q_item.x_high[CW-1:0],
                      q_item.y_low[CW-1:0], q_item.x_low[CW-1:0]};
  assign ram_raddr = rd_idx_r[SW-1:0];

  rnbe_ram #(.WIDTH(RW), .DEPTH(NODE_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stage one: extents of the slot and of the grown rectangle.
  logic [CW-1:0] rxl, ryl, rxh, ryh, qxl, qyl, qxh, qyh;
  logic [CW-1:0] gxl, gyl, gxh, gyh, w, h, gw, gh;
  always_comb begin
    rxl = ram_rdata[CW-1:0];
    ryl = ram_rdata[2*CW-1:CW];
    rxh = ram_rdata[3*CW-1:2*CW];
    ryh = ram_rdata[4*CW-1:3*CW];
    qxl = op_r.x_low[CW-1:0];
    qyl = op_r.y_low[CW-1:0];
    qxh = op_r.x_high[CW-1:0];
    qyh = op_r.y_high[CW-1:0];
    gxl = (qxl < rxl) ? qxl : rxl;
    gyl = (qyl < ryl) ? qyl : ryl;
    gxh = (qxh > rxh) ? qxh : rxh;
    gyh = (qyh > ryh) ? qyh : ryh;
    w   = (rxh >= rxl) ? rxh - rxl : '0;
    h   = (ryh >= ryl) ? ryh - ryl : '0;
    gw  = (gxh >= gxl) ? gxh - gxl : '0;
    gh  = (gyh >= gyl) ? gyh - gyl : '0;
  end

  // Stage two: growth of the registered slot.
  logic [AW-1:0] inc;
  logic          better, same;
  assign inc    = s2_ga_r - s2_a_r;
  assign better = (status_r != ST_DONE) || (inc < best_inc_r) ||
                  (inc == best_inc_r && s2_a_r < best_a_r);
  assign same   = (s2_xl_r == qxl) && (s2_yl_r == qyl) &&
                  (s2_xh_r == qxh) && (s2_yh_r == qyh);

  // Sequencer, walk pipeline, accumulators and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      rd_idx_r  <= '0;
    end else begin
      // Result register: load a finished operation or release an accepted word.
      if (load_res) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_ready) begin
        out_vld_r <= 1'b0;
      end
      // Read issue and pipeline stages.
      s1_vld_r <= (state_r == S_WALK) && (rd_idx_r < (SW+1)'(NODE_SLOTS));
      s1_idx_r <= rd_idx_r[SW-1:0];
      if ((state_r == S_WALK) && (rd_idx_r < (SW+1)'(NODE_SLOTS))) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      s2_vld_r   <= s1_vld_r;
      s2_live_r  <= valid_r[s1_idx_r];
      s2_idx_r   <= s1_idx_r;
      s2_a_r     <= AW'(w) * AW'(h);
      s2_ga_r    <= AW'(gw) * AW'(gh);
      s2_xl_r    <= rxl;
      s2_yl_r    <= ryl;
      s2_xh_r    <= rxh;
      s2_yh_r    <= ryh;
      s2_child_r <= ram_rdata[RW-1:4*CW];

      unique case (state_r)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            op_r     <= q_item;
            rd_idx_r <= '0;
            any_r    <= 1'b0;
            cxl_r    <= '0;
            cyl_r    <= '0;
            cxh_r    <= '0;
            cyh_r    <= '0;
            slot_r   <= 4'd0;
            child_r  <= '0;
            state_r  <= S_WALK;
            unique case (q_item.func)
              FN_INSERT: begin
                if (free_any) begin
                  valid_r[free_idx] <= 1'b1;
                  status_r <= ST_DONE;
                  slot_r   <= low4(free_idx);
                  child_r  <= q_item.child_ref;
                end else begin
                  status_r <= ST_FULL;
                end
              end
              FN_CHOOSE: status_r <= ST_EMPTY;
              FN_CLEAR: begin
                slot_r    <= q_item.slot_index;
                clr_idx_r <= sx[SW-1:0];
                if (clr_hit) begin
                  valid_r[sx[SW-1:0]] <= 1'b0;
                  status_r <= ST_DONE;
                end else begin
                  status_r <= ST_MISS;
                end
              end
              default: status_r <= ST_MISS;
            endcase
          end
        end
        S_WALK: begin
          if (s2_vld_r) begin
            if (s2_live_r) begin
              any_r <= 1'b1;
              cxl_r <= (!any_r || s2_xl_r < cxl_r) ? s2_xl_r : cxl_r;
              cyl_r <= (!any_r || s2_yl_r < cyl_r) ? s2_yl_r : cyl_r;
              cxh_r <= (!any_r || s2_xh_r > cxh_r) ? s2_xh_r : cxh_r;
              cyh_r <= (!any_r || s2_yh_r > cyh_r) ? s2_yh_r : cyh_r;
              if (op_r.func == FN_CHOOSE && better) begin
                status_r   <= ST_DONE;
                best_inc_r <= inc;
                best_a_r   <= s2_a_r;
                slot_r     <= low4(s2_idx_r);
                child_r    <= s2_child_r;
              end
              if (op_r.func == FN_FIND && status_r != ST_DONE && same) begin
                status_r <= ST_DONE;
                slot_r   <= low4(s2_idx_r);
                child_r  <= s2_child_r;
              end
            end
            // A cleared slot still holds its child reference in memory.
            if (op_r.func == FN_CLEAR && status_r == ST_DONE && s2_idx_r == clr_idx_r) begin
              child_r <= s2_child_r;
            end
            if (s2_idx_r == SW'(NODE_SLOTS - 1)) begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (load_res) begin
            res_r.status       <= status_r;
            res_r.chosen_slot  <= slot_r;
            res_r.chosen_child <= child_r;
            res_r.cover_x_low  <= FIELD_W'(cxl_r);
            res_r.cover_y_low  <= FIELD_W'(cyl_r);
            res_r.cover_x_high <= FIELD_W'(cxh_r);
            res_r.cover_y_high <= FIELD_W'(cyh_r);
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = res_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rnbe_checker.sv =====
// Port-level checker for the R-tree node branch engine, bound to the top level.
`default_nettype none
module rnbe_checker import rnbe_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TDATA_W-1:0] out_tdata
);

  // A waiting result word holds steady.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Reset leaves no result pending.
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A full node reports no slot and no child.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_FULL |-> out_tdata[29:2] == 28'd0)
    else $error("full status with nonzero slot or child");

  // An empty node has an empty cover and no slot.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_EMPTY |-> out_tdata[93:2] == 92'd0)
    else $error("empty status with nonzero fields");

  // Padding bits stay zero.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[95:94] == 2'b00)
    else $error("nonzero padding in result word");

endmodule

bind rtree_node_branch_engine_core rnbe_checker u_rnbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
